FILE: rtl/core/rbvg_pkg.sv
// rbvg_pkg: shared constants, tables and types for the rounded blob vertex generator.
// No dependencies; imported by rbvg_sincos, rbvg_atan2 and rounded_blob_vertex_gen_core.
package rbvg_pkg;

   localparam int ARC_SEGMENTS = 8;
   localparam int ARC_POINTS   = ARC_SEGMENTS + 1;
   localparam int RIM_COUNT    = 4 * ARC_POINTS;
   localparam int CORDIC_STEPS = 15;
   localparam int ATAN_DEPTH   = 16;

   // rotation cordic: steps folded into each register stage
   localparam int SC_PER    = 3;
   localparam int SC_STAGES = (CORDIC_STEPS + SC_PER - 1) / SC_PER;
   localparam int SC_LAT    = SC_STAGES + 2;
   localparam int SC_W      = 19;
   localparam int SC_AW     = 17;

   // vectoring cordic and the divider that runs beside it
   localparam int AT_PER    = 2;
   localparam int AT_STAGES = (CORDIC_STEPS + AT_PER - 1) / AT_PER;
   localparam int AT_LAT    = AT_STAGES + 1;
   localparam int AT_W      = 44;
   localparam int DX_W      = 26;
   localparam int T_BITS    = 16;
   localparam int DIV_PER   = (T_BITS + AT_STAGES - 1) / AT_STAGES;

   localparam int PIPE_LAT  = 2 + SC_LAT + 2 + AT_LAT + 1 + SC_LAT + 3;

   localparam int RECIP_SHIFT = 24;
   localparam logic [20:0] RECIP10 = 21'(((1 << RECIP_SHIFT) + 9) / 10);
   localparam logic [22:0] WOB_MIN = 23'd3;

   localparam logic signed [SC_W-1:0] SC_INIT = 19'sd39797;

   localparam logic [13:0] ATAN_TURN [ATAN_DEPTH] = '{
      14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
      14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1, 14'd1, 14'd0
   };

   localparam logic [15:0] CORNER_START [4] = '{16'h8000, 16'hC000, 16'h0000, 16'h4000};

   typedef enum logic {
      CSR_TOP_COLOR    = 1'b0,
      CSR_BOTTOM_COLOR = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [SC_W-1:0] s;
      logic signed [SC_W-1:0] c;
   } sincos_type;

   // corner of a rim point, found by comparing against the corner boundaries
   function automatic logic [1:0] arc_quarter(input logic [5:0] k);
      if (k >= 6'(3 * ARC_POINTS)) begin
         return 2'd3;
      end
      if (k >= 6'(2 * ARC_POINTS)) begin
         return 2'd2;
      end
      if (k >= 6'(ARC_POINTS)) begin
         return 2'd1;
      end
      return 2'd0;
   endfunction

   function automatic logic [3:0] arc_point(input logic [5:0] k);
      logic [5:0] base;
      base = 6'(ARC_POINTS) * {4'b0000, arc_quarter(k)};
      return 4'(k - base);
   endfunction

   function automatic logic [15:0] arc_offset(input logic [3:0] i);
      return 16'((int'(i) * 16384 + ARC_SEGMENTS / 2) / ARC_SEGMENTS);
   endfunction

endpackage

FILE: rtl/core/rbvg_sincos.sv
// rbvg_sincos: pipelined rotation cordic giving sine and cosine of a 16-bit turn fraction.
// Depends on rbvg_pkg; all stages and the result register advance only while en is high.
module rbvg_sincos (
   input  logic                  clock,
   input  logic                  en,
   input  logic [15:0]           angle,
   output rbvg_pkg::sincos_type  result
);
   import rbvg_pkg::*;

   typedef struct packed {
      logic signed [SC_W-1:0]  x;
      logic signed [SC_W-1:0]  y;
      logic signed [SC_AW-1:0] z;
      logic                    flip;
   } rot_type;

   rot_type    st_ff [SC_STAGES+1];
   rot_type    st_in [SC_STAGES+1];
   sincos_type res_ff;
   sincos_type res_in;

   // fold the angle into the right half plane
   always_comb begin
      logic signed [SC_AW-1:0] t;
      logic                    fl;
      t  = SC_AW'($signed(angle));
      fl = 1'b0;
      if (t > 17'sd16384) begin
         t  = t - 17'sd32768;
         fl = 1'b1;
      end else if (t < -17'sd16384) begin
         t  = t + 17'sd32768;
         fl = 1'b1;
      end
      st_in[0] = '{x: SC_INIT, y: '0, z: t, flip: fl};
   end

   for (genvar j = 1; j <= SC_STAGES; j++) begin : g_stage
      always_comb begin
         rot_type                r;
         logic signed [SC_W-1:0] dx;
         logic signed [SC_W-1:0] dy;
         r = st_ff[j-1];
         for (int m = 0; m < SC_PER; m++) begin
            if ((j - 1) * SC_PER + m < CORDIC_STEPS) begin
               dx = r.y >>> ((j - 1) * SC_PER + m);
               dy = r.x >>> ((j - 1) * SC_PER + m);
               if (r.z >= 0) begin
                  r.x = r.x - dx;
                  r.y = r.y + dy;
                  r.z = r.z - $signed({3'b000, ATAN_TURN[(j - 1) * SC_PER + m]});
               end else begin
                  r.x = r.x + dx;
                  r.y = r.y - dy;
                  r.z = r.z + $signed({3'b000, ATAN_TURN[(j - 1) * SC_PER + m]});
               end
            end
         end
         st_in[j] = r;
      end
   end

   always_comb begin
      if (st_ff[SC_STAGES].flip) begin
         res_in.s = -st_ff[SC_STAGES].y;
         res_in.c = -st_ff[SC_STAGES].x;
      end else begin
         res_in.s = st_ff[SC_STAGES].y;
         res_in.c = st_ff[SC_STAGES].x;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= SC_STAGES; k++) begin
            st_ff[k] <= st_in[k];
         end
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

FILE: rtl/core/rbvg_atan2.sv
// rbvg_atan2: pipelined vectoring cordic, angle of (dx, dy) as a 16-bit turn fraction.
// Depends on rbvg_pkg; all stages advance only while en is high, and a zero vector gives 0.
module rbvg_atan2 (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [rbvg_pkg::DX_W-1:0] dx,
   input  logic signed [rbvg_pkg::DX_W-1:0] dy,
   output logic [15:0]                   angle
);
   import rbvg_pkg::*;

   typedef struct packed {
      logic signed [AT_W-1:0] x;
      logic signed [AT_W-1:0] y;
      logic [15:0]            z;
      logic                   zero;
   } vec_type;

   vec_type st_ff [AT_STAGES+1];
   vec_type st_in [AT_STAGES+1];

   always_comb begin
      vec_type v;
      v.zero = (dx == '0) && (dy == '0);
      v.x    = {{(AT_W - DX_W - 16){dx[DX_W-1]}}, dx, 16'h0000};
      v.y    = {{(AT_W - DX_W - 16){dy[DX_W-1]}}, dy, 16'h0000};
      v.z    = 16'h0000;
      if (dx < 0) begin
         v.x = -v.x;
         v.y = -v.y;
         v.z = 16'h8000;
      end
      st_in[0] = v;
   end

   for (genvar j = 1; j <= AT_STAGES; j++) begin : g_stage
      always_comb begin
         vec_type                r;
         logic signed [AT_W-1:0] sx;
         logic signed [AT_W-1:0] sy;
         r = st_ff[j-1];
         for (int m = 0; m < AT_PER; m++) begin
            if ((j - 1) * AT_PER + m < CORDIC_STEPS) begin
               sx = r.y >>> ((j - 1) * AT_PER + m);
               sy = r.x >>> ((j - 1) * AT_PER + m);
               if (r.y > 0) begin
                  r.x = r.x + sx;
                  r.y = r.y - sy;
                  r.z = r.z + {2'b00, ATAN_TURN[(j - 1) * AT_PER + m]};
               end else begin
                  r.x = r.x - sx;
                  r.y = r.y + sy;
                  r.z = r.z - {2'b00, ATAN_TURN[(j - 1) * AT_PER + m]};
               end
            end
         end
         st_in[j] = r;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= AT_STAGES; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign angle = st_ff[AT_STAGES].zero ? 16'h0000 : st_ff[AT_STAGES].z;

endmodule

FILE: rtl/core/rounded_blob_vertex_gen_core.sv
// rounded_blob_vertex_gen_core: top level, one rounded-rectangle fan vertex per request.
// Depends on rbvg_pkg, rbvg_sincos and rbvg_atan2.
// Depth: PIPE_LAT = 31 register stages, one valid bit per stage.
// Throughput: one request per cycle while no response is held; the pipeline length is set by two 15-step cordic
// sine units in series with a 15-step vectoring cordic and the 16-bit divider beside it.
// A held response stalls every stage at once; nothing is dropped or repeated.
// Reset clears the stage valid bits and both color registers.
module rounded_blob_vertex_gen_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  rbvg_pkg::csr_index_type       csr_index,
   input  logic [31:0]                   csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [23:0]            req_center_x,
   input  logic signed [23:0]            req_center_y,
   input  logic [22:0]                   req_shape_width,
   input  logic [22:0]                   req_shape_height,
   input  logic [22:0]                   req_corner_radius,
   input  logic [22:0]                   req_wobble_amp,
   input  logic [15:0]                   req_wobble_phase,
   input  logic [5:0]                    req_vertex_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [23:0]            rsp_pos_x,
   output logic signed [23:0]            rsp_pos_y,
   output logic [31:0]                   rsp_vertex_color,
   output logic [5:0]                    rsp_fan_next_index,
   output logic                          rsp_is_center
);
   import rbvg_pkg::*;

   typedef struct packed {
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic [22:0]        hw;
      logic [22:0]        hh;
      logic [22:0]        r9c;
      logic [22:0]        amp;
      logic [15:0]        phase;
      logic [5:0]         idx;
      logic [19:0]        ph13;
      logic               is_center;
   } s1_type;

   typedef struct packed {
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic [22:0]        r9c;
      logic [22:0]        amp;
      logic [15:0]        phase;
      logic               is_center;
      logic [5:0]         fan_next;
      logic               wob_en;
      logic signed [23:0] dx0;
      logic signed [23:0] dy0;
      logic signed [24:0] numbase;
      logic [23:0]        den;
      logic [15:0]        p13;
   } ctxa_type;

   typedef struct packed {
      ctxa_type           a;
      logic signed [24:0] pc;
      logic signed [24:0] ps;
   } s3_type;

   typedef struct packed {
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic [22:0]        amp;
      logic [15:0]        phase;
      logic [15:0]        p13;
      logic               is_center;
      logic [5:0]         fan_next;
      logic               wob_en;
      logic signed [26:0] vx;
      logic signed [26:0] vy;
   } ctxb_type;

   typedef struct packed {
      logic signed [DX_W-1:0] dx;
      logic signed [DX_W-1:0] dy;
      logic signed [26:0]     num;
      logic [23:0]            den;
   } s4x_type;

   typedef struct packed {
      logic [23:0]       rem;
      logic [T_BITS-1:0] q;
      logic              neg;
      logic              full;
      logic [23:0]       den;
   } div_type;

   typedef struct packed {
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic [22:0]        amp;
      logic               is_center;
      logic [5:0]         fan_next;
      logic               wob_en;
      logic signed [26:0] vx;
      logic signed [26:0] vy;
      logic [16:0]        t;
   } ctxc_type;

   typedef struct packed {
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic               is_center;
      logic [5:0]         fan_next;
      logic               wob_en;
      logic signed [26:0] vx;
      logic signed [26:0] vy;
      logic [31:0]        color;
      logic signed [25:0] wob;
      logic signed [SC_W-1:0] ct;
      logic signed [SC_W-1:0] st;
   } s6_type;

   typedef struct packed {
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic               is_center;
      logic [5:0]         fan_next;
      logic signed [26:0] vx;
      logic signed [26:0] vy;
      logic [31:0]        color;
      logic signed [25:0] px;
      logic signed [25:0] py;
   } s7_type;

   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [31:0]        color;
      logic [5:0]         fan_next;
      logic               is_center;
   } out_type;

   logic                adv;
   logic [PIPE_LAT-1:0] vld_ff;
   logic [31:0]         top_color_ff;
   logic [31:0]         bottom_color_ff;

   s1_type      s1_ff, s1_in;
   ctxa_type    s2_ff, s2_in;
   logic [15:0] s2_ang_ff, s2_ang_in;
   ctxa_type    ca_ff [SC_LAT];
   sincos_type  arc_sc;
   s3_type      s3_ff, s3_in;
   ctxb_type    s4_ff, s4_in;
   s4x_type     s4x_ff, s4x_in;
   ctxb_type    cb_ff [AT_LAT];
   div_type     div_ff [AT_STAGES+1];
   div_type     div_in [AT_STAGES+1];
   logic [15:0] th_raw;
   ctxc_type    s5_ff, s5_in;
   logic [15:0] s5_th_ff, s5_a1_ff, s5_a2_ff;
   logic [15:0] s5_th_in, s5_a1_in, s5_a2_in;
   ctxc_type    cc_ff [SC_LAT];
   sincos_type  th_sc, a1_sc, a2_sc;
   s6_type      s6_ff, s6_in;
   s7_type      s7_ff, s7_in;
   out_type     out_ff, out_in;

   // the whole pipeline moves unless a finished response is held
   assign adv       = !vld_ff[PIPE_LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_color_ff    <= '0;
         bottom_color_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TOP_COLOR:    top_color_ff    <= csr_data;
            CSR_BOTTOM_COLOR: bottom_color_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 1: radius clamp, index clamp
   always_comb begin
      logic [22:0] lim;
      logic [23:0] r9;
      lim = (req_shape_width < req_shape_height) ? req_shape_width : req_shape_height;
      r9  = {req_corner_radius, 1'b0};
      s1_in.cx    = req_center_x;
      s1_in.cy    = req_center_y;
      s1_in.hw    = req_shape_width;
      s1_in.hh    = req_shape_height;
      s1_in.r9c   = (r9 > {1'b0, lim}) ? lim : r9[22:0];
      s1_in.amp   = req_wobble_amp;
      s1_in.phase = req_wobble_phase;
      s1_in.idx   = (req_vertex_index > 6'(RIM_COUNT)) ? 6'(RIM_COUNT) : req_vertex_index;
      s1_in.ph13  = {4'h0, req_wobble_phase} * 20'd13 + 20'd5;
      s1_in.is_center = (req_vertex_index == 6'd0);
   end

   // stage 2: corner selection, arc angle, offsets from the center
   always_comb begin
      logic [5:0]  k;
      logic [1:0]  q;
      logic [22:0] offx;
      logic [22:0] offy;
      logic [40:0] pr;
      k    = s1_ff.idx - 6'd1;
      q    = arc_quarter(k);
      offx = s1_ff.hw - s1_ff.r9c;
      offy = s1_ff.hh - s1_ff.r9c;
      pr   = 41'(s1_ff.ph13) * 41'(RECIP10);
      s2_ang_in = CORNER_START[q] + arc_offset(arc_point(k));
      s2_in.cx        = s1_ff.cx;
      s2_in.cy        = s1_ff.cy;
      s2_in.r9c       = s1_ff.r9c;
      s2_in.amp       = s1_ff.amp;
      s2_in.phase     = s1_ff.phase;
      s2_in.is_center = s1_ff.is_center;
      if (s1_ff.is_center) begin
         s2_in.fan_next = 6'd0;
      end else if (s1_ff.idx == 6'(RIM_COUNT)) begin
         s2_in.fan_next = 6'd1;
      end else begin
         s2_in.fan_next = s1_ff.idx + 6'd1;
      end
      s2_in.wob_en = (s1_ff.amp >= WOB_MIN);
      // left corners are top-left and bottom-left
      s2_in.dx0 = (q == 2'd0 || q == 2'd3) ? -$signed({1'b0, offx}) : $signed({1'b0, offx});
      s2_in.dy0 = (q < 2'd2) ? -$signed({1'b0, offy}) : $signed({1'b0, offy});
      s2_in.numbase = (q < 2'd2) ? $signed({2'b00, s1_ff.r9c})
                                 : $signed({1'b0, s1_ff.hh, 1'b0}) - $signed({2'b00, s1_ff.r9c});
      s2_in.den = ({s1_ff.hh, 1'b0} < 24'd512) ? 24'd512 : {s1_ff.hh, 1'b0};
      s2_in.p13 = pr[RECIP_SHIFT+15:RECIP_SHIFT];
   end

   rbvg_sincos u_arc_sc (.clock(clock), .en(adv), .angle(s2_ang_ff), .result(arc_sc));

   // stage 3: scale the unit arc point by the radius
   always_comb begin
      logic signed [42:0] mc;
      logic signed [42:0] ms;
      mc = arc_sc.c * $signed({1'b0, ca_ff[SC_LAT-1].r9c});
      ms = arc_sc.s * $signed({1'b0, ca_ff[SC_LAT-1].r9c});
      s3_in.a  = ca_ff[SC_LAT-1];
      s3_in.pc = 25'((mc + 43'sd32768) >>> 16);
      s3_in.ps = 25'((ms + 43'sd32768) >>> 16);
   end

   // stage 4: absolute vertex, vector from the center, gradient numerator
   always_comb begin
      logic signed [26:0] cx9;
      logic signed [26:0] cy9;
      cx9 = 27'($signed({s3_ff.a.cx, 1'b0}));
      cy9 = 27'($signed({s3_ff.a.cy, 1'b0}));
      s4_in.cx        = s3_ff.a.cx;
      s4_in.cy        = s3_ff.a.cy;
      s4_in.amp       = s3_ff.a.amp;
      s4_in.phase     = s3_ff.a.phase;
      s4_in.p13       = s3_ff.a.p13;
      s4_in.is_center = s3_ff.a.is_center;
      s4_in.fan_next  = s3_ff.a.fan_next;
      s4_in.wob_en    = s3_ff.a.wob_en;
      s4_in.vx = cx9 + 27'(s3_ff.a.dx0) + 27'(s3_ff.pc);
      s4_in.vy = cy9 + 27'(s3_ff.a.dy0) + 27'(s3_ff.ps);
      s4x_in.dx  = DX_W'(s3_ff.a.dx0) + DX_W'(s3_ff.pc);
      s4x_in.dy  = DX_W'(s3_ff.a.dy0) + DX_W'(s3_ff.ps);
      s4x_in.num = 27'(s3_ff.a.numbase) + 27'(s3_ff.ps);
      s4x_in.den = s3_ff.a.den;
   end

   rbvg_atan2 u_atan (.clock(clock), .en(adv), .dx(s4x_ff.dx), .dy(s4x_ff.dy), .angle(th_raw));

   // restoring divider for the gradient factor, in step with the vectoring cordic
   always_comb begin
      div_in[0].neg  = (s4x_ff.num <= 0);
      div_in[0].full = (s4x_ff.num >= $signed({3'b000, s4x_ff.den}));
      div_in[0].rem  = s4x_ff.num[23:0];
      div_in[0].q    = '0;
      div_in[0].den  = s4x_ff.den;
   end

   for (genvar j = 1; j <= AT_STAGES; j++) begin : g_div
      always_comb begin
         div_type     d;
         logic [24:0] r2;
         d = div_ff[j-1];
         for (int m = 0; m < DIV_PER; m++) begin
            if ((j - 1) * DIV_PER + m < T_BITS) begin
               r2 = {d.rem, 1'b0};
               if (r2 >= {1'b0, d.den}) begin
                  d.rem = 24'(r2 - {1'b0, d.den});
                  d.q   = {d.q[T_BITS-2:0], 1'b1};
               end else begin
                  d.rem = r2[23:0];
                  d.q   = {d.q[T_BITS-2:0], 1'b0};
               end
            end
         end
         div_in[j] = d;
      end
   end

   // stage 5: wobble angles and final blend factor
   always_comb begin
      ctxb_type b;
      b = cb_ff[AT_LAT-1];
      s5_th_in = th_raw;
      s5_a1_in = th_raw + {th_raw[14:0], 1'b0} + b.phase;
      s5_a2_in = th_raw + {th_raw[13:0], 2'b00} - b.p13;
      s5_in.cx        = b.cx;
      s5_in.cy        = b.cy;
      s5_in.amp       = b.amp;
      s5_in.is_center = b.is_center;
      s5_in.fan_next  = b.fan_next;
      s5_in.wob_en    = b.wob_en;
      s5_in.vx        = b.vx;
      s5_in.vy        = b.vy;
      priority if (b.is_center) begin
         s5_in.t = 17'd32768;
      end else if (div_ff[AT_STAGES].neg) begin
         s5_in.t = 17'd0;
      end else if (div_ff[AT_STAGES].full) begin
         s5_in.t = 17'd65536;
      end else begin
         s5_in.t = {1'b0, div_ff[AT_STAGES].q};
      end
   end

   rbvg_sincos u_th_sc (.clock(clock), .en(adv), .angle(s5_th_ff), .result(th_sc));
   rbvg_sincos u_a1_sc (.clock(clock), .en(adv), .angle(s5_a1_ff), .result(a1_sc));
   rbvg_sincos u_a2_sc (.clock(clock), .en(adv), .angle(s5_a2_ff), .result(a2_sc));

   // stage 6: wobble magnitude and color gradient
   always_comb begin
      ctxc_type           c;
      logic signed [20:0] sum;
      logic signed [45:0] wm;
      logic signed [8:0]  diff;
      logic signed [26:0] bp;
      logic signed [9:0]  bv;
      c   = cc_ff[SC_LAT-1];
      sum = (21'(a1_sc.s) <<< 1) + 21'(a2_sc.s);
      wm  = $signed({1'b0, c.amp, 1'b0}) * sum;
      s6_in.wob = 26'((wm + 46'sd65536) >>> 17);
      s6_in.ct  = th_sc.c;
      s6_in.st  = th_sc.s;
      for (int ch = 0; ch < 4; ch++) begin
         diff = $signed({1'b0, bottom_color_ff[ch*8 +: 8]})
              - $signed({1'b0, top_color_ff[ch*8 +: 8]});
         bp   = diff * $signed({1'b0, c.t});
         bv   = $signed({2'b00, top_color_ff[ch*8 +: 8]}) + 10'((bp + 27'sd32768) >>> 16);
         s6_in.color[ch*8 +: 8] = bv[7:0];
      end
      s6_in.cx        = c.cx;
      s6_in.cy        = c.cy;
      s6_in.is_center = c.is_center;
      s6_in.fan_next  = c.fan_next;
      s6_in.wob_en    = c.wob_en;
      s6_in.vx        = c.vx;
      s6_in.vy        = c.vy;
   end

   // stage 7: radial push
   always_comb begin
      logic signed [44:0] pmx;
      logic signed [44:0] pmy;
      pmx = s6_ff.ct * s6_ff.wob;
      pmy = s6_ff.st * s6_ff.wob;
      s7_in.px = s6_ff.wob_en ? 26'((pmx + 45'sd32768) >>> 16) : '0;
      s7_in.py = s6_ff.wob_en ? 26'((pmy + 45'sd32768) >>> 16) : '0;
      s7_in.cx        = s6_ff.cx;
      s7_in.cy        = s6_ff.cy;
      s7_in.is_center = s6_ff.is_center;
      s7_in.fan_next  = s6_ff.fan_next;
      s7_in.vx        = s6_ff.vx;
      s7_in.vy        = s6_ff.vy;
      s7_in.color     = s6_ff.color;
   end

   function automatic logic signed [23:0] to_q8(input logic signed [26:0] v,
                                                input logic signed [25:0] p);
      logic signed [27:0] s;
      logic signed [27:0] h;
      s = 28'(v) + 28'(p) + 28'sd1;
      h = s >>> 1;
      if (h > 28'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (h < -28'sd8388608) begin
         return 24'sh800000;
      end
      return h[23:0];
   endfunction

   // stage 8: output register
   always_comb begin
      if (s7_ff.is_center) begin
         out_in.pos_x = s7_ff.cx;
         out_in.pos_y = s7_ff.cy;
      end else begin
         out_in.pos_x = to_q8(s7_ff.vx, s7_ff.px);
         out_in.pos_y = to_q8(s7_ff.vy, s7_ff.py);
      end
      out_in.color     = s7_ff.color;
      out_in.fan_next  = s7_ff.fan_next;
      out_in.is_center = s7_ff.is_center;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         s2_ang_ff <= s2_ang_in;
         ca_ff[0]  <= s2_ff;
         for (int k = 1; k < SC_LAT; k++) begin
            ca_ff[k] <= ca_ff[k-1];
         end
         s3_ff    <= s3_in;
         s4_ff    <= s4_in;
         s4x_ff   <= s4x_in;
         cb_ff[0] <= s4_ff;
         for (int k = 1; k < AT_LAT; k++) begin
            cb_ff[k] <= cb_ff[k-1];
         end
         for (int k = 0; k <= AT_STAGES; k++) begin
            div_ff[k] <= div_in[k];
         end
         s5_ff    <= s5_in;
         s5_th_ff <= s5_th_in;
         s5_a1_ff <= s5_a1_in;
         s5_a2_ff <= s5_a2_in;
         cc_ff[0] <= s5_ff;
         for (int k = 1; k < SC_LAT; k++) begin
            cc_ff[k] <= cc_ff[k-1];
         end
         s6_ff  <= s6_in;
         s7_ff  <= s7_in;
         out_ff <= out_in;
      end
   end

   assign rsp_valid          = vld_ff[PIPE_LAT-1];
   assign rsp_pos_x          = out_ff.pos_x;
   assign rsp_pos_y          = out_ff.pos_y;
   assign rsp_vertex_color   = out_ff.color;
   assign rsp_fan_next_index = out_ff.fan_next;
   assign rsp_is_center      = out_ff.is_center;

   a_center_no_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_center |-> rsp_fan_next_index == 6'd0)
      else $error("center vertex with nonzero fan index");

   a_rim_next_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_center |->
         rsp_fan_next_index != 6'd0 && rsp_fan_next_index <= 6'(RIM_COUNT))
      else $error("rim vertex fan index out of range");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(vld_ff))
      else $error("pipeline moved while response held");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> vld_ff == '0)
      else $error("valid bits survive reset");

endmodule
